// File: rtl/sle_pkg.sv
// Shared types, constants and fixed-point helpers of the Lennard-Jones evaluator.
package sle_pkg;

  // Divider bits resolved per pipeline stage; must divide 64 and 88.
  localparam int unsigned DIV_STEP = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [63:0]        CAPV     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]        CAP_DIV4 = CAPV / 64'd4;
  localparam logic [63:0]        CAP_DIV24 = CAPV / 64'd24;
  localparam logic signed [63:0] ONEQ     = 64'sh1_0000_0000;
  localparam logic signed [64:0] SCAP     = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] NSCAP    = -SCAP;
  localparam logic signed [63:0] OMAX48   = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OMIN48   = -64'sh8000_0000_0000;

  localparam logic [31:0] SIGMA_RST  = 32'd16777216;
  localparam logic [46:0] EPS_RST    = 47'd429496730;
  localparam logic [31:0] CUTOFF_RST = 32'd33554432;
  localparam logic [31:0] TRUNC_RST  = 32'd15099494;

  typedef enum logic [2:0] {
    REG_SIGMA       = 3'd0,
    REG_WELL_DEPTH  = 3'd1,
    REG_CUTOFF      = 3'd2,
    REG_POT_CUTOFF  = 3'd3,
    REG_DER_CUTOFF  = 3'd4,
    REG_TRUNC       = 3'd5,
    REG_POT_TRUNC   = 3'd6,
    REG_DER_TRUNC   = 3'd7
  } sle_cfg_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } sle_status_e;

  typedef enum logic [2:0] {
    CS_NEG   = 3'd0,
    CS_TRUNC = 3'd1,
    CS_CUT   = 3'd2,
    CS_ZERO  = 3'd3,
    CS_LJ    = 3'd4
  } sle_case_e;

  typedef struct packed {
    sle_case_e   cs;
    logic [31:0] x;
  } sle_ctx_t;

  typedef struct packed {
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [63:0] ll;
  } sle_pp_t;

  // four 32x32 partial products of a 64x64 product
  function automatic sle_pp_t pp_of(input logic [63:0] a, input logic [63:0] b);
    sle_pp_t p;
    p.hh = 64'(a[63:32]) * 64'(b[63:32]);
    p.hl = 64'(a[63:32]) * 64'(b[31:0]);
    p.lh = 64'(a[31:0]) * 64'(b[63:32]);
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    return p;
  endfunction

  // Q.32 product from partials, saturating at CAPV
  function automatic logic [63:0] umulq_fin(input sle_pp_t p);
    logic [65:0] s;
    logic        sat;
    s = {3'b0, p.hh[30:0], 32'b0} + {2'b0, p.hl} + {2'b0, p.lh} + {34'b0, p.ll[63:32]};
    sat = (|p.hh[63:31]) || (s > {2'b0, CAPV});
    return sat ? CAPV : s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > SCAP) begin
      return SCAP[63:0];
    end else if (s < NSCAP) begin
      return NSCAP[63:0];
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [63:0] mk(input logic neg, input logic [63:0] m);
    logic [63:0] mm;
    mm = (m > CAPV) ? CAPV : m;
    return neg ? -$signed(mm) : $signed(mm);
  endfunction

  function automatic logic signed [63:0] sx48(input logic [47:0] v);
    return {{16{v[47]}}, v};
  endfunction

  // {saturated, value}
  function automatic logic [48:0] clamp48(input logic signed [63:0] v);
    if (v > OMAX48) begin
      return {1'b1, OMAX48[47:0]};
    end else if (v < OMIN48) begin
      return {1'b1, OMIN48[47:0]};
    end
    return {1'b0, v[47:0]};
  endfunction

endpackage

// File: rtl/sle_in_if.sv
// Request channel: mode and distance.
interface sle_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] distance;

  modport source (output valid, mode, distance, input ready);
  modport sink   (input valid, mode, distance, output ready);
endinterface

// File: rtl/sle_out_if.sv
// Result channel: potential, derivative and status.
interface sle_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] potential;
  logic signed [47:0] derivative;
  logic [1:0]         status;

  modport source (output valid, potential, derivative, status, input ready);
  modport sink   (input valid, potential, derivative, status, output ready);
endinterface

// File: rtl/sle_div_pipe.sv
// Pipelined restoring divider, STEP quotient bits per stage, with sideband.
module sle_div_pipe #(
  parameter int unsigned NUM_W  = 64,
  parameter int unsigned DEN_W  = 31,
  parameter int unsigned STEP   = 4,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned NSTG = NUM_W / STEP;

  logic              vld_q  [NSTG];
  logic [NUM_W-1:0]  acc_q  [NSTG];  // numerator bits left, quotient bits shift in
  logic [DEN_W-1:0]  rem_q  [NSTG];
  logic [DEN_W-1:0]  den_q  [NSTG];
  logic [SIDE_W-1:0] side_q [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic              vld_in;
    logic [NUM_W-1:0]  acc_in, acc_d;
    logic [DEN_W-1:0]  rem_in, rem_d, den_in;
    logic [SIDE_W-1:0] side_in;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign acc_in  = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign acc_in  = acc_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [DEN_W:0]   part;
      logic [DEN_W+1:0] diff;
      acc_d = acc_in;
      rem_d = rem_in;
      part  = '0;
      diff  = '0;
      for (int b = 0; b < STEP; b++) begin
        part  = {rem_d, acc_d[NUM_W-1]};
        diff  = {1'b0, part} - {2'b0, den_in};
        acc_d = {acc_d[NUM_W-2:0], ~diff[DEN_W+1]};
        rem_d = diff[DEN_W+1] ? part[DEN_W-1:0] : diff[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s]  <= acc_d;
        rem_q[s]  <= rem_d;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NSTG-1];
  assign quo_o  = acc_q[NSTG-1];
  assign side_o = side_q[NSTG-1];

endmodule

// File: rtl/shifted_lennard_jones_eval_top.sv
// Shifted-force Lennard-Jones evaluator: top level pipeline and registers.
//
//  channel   dir  handshake            payload
//  req_i     in   valid/ready          mode, distance (Q8.24)
//  rsp_o     out  valid/ready          potential, derivative (Q16.32), status
//  cfg_*     in   cfg_we_i, no stall   cfg_idx_i, cfg_data_i
//
// One request per cycle sustained while rsp_o is not stalled. The pipeline runs
// through the two divider pipelines (sigma/x and the derivative's division by x)
// and, between them, the multiply chain for (sigma/x)^6 in stages A..M.
// Reset clears all valid bits and loads the register defaults.
// A result held at rsp_o freezes the whole pipeline; nothing is dropped or
// duplicated, and req_i.ready follows the freeze.
module shifted_lennard_jones_eval_top #(
  parameter int unsigned DIV_STEP = sle_pkg::DIV_STEP
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sle_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sle_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  sle_in_if.sink                          req_i,
  sle_out_if.source                       rsp_o
);
  import sle_pkg::*;

  localparam int unsigned N_MID = 13;  // stages A..M between dividers

  typedef struct packed {
    sle_ctx_t           ctx;
    logic               nk;
    logic signed [63:0] pot;
    logic signed [63:0] ptr;
  } d2side_t;

  // ---------------- configuration registers
  logic [31:0] sigma_q, cut_q, trd_q;
  logic [46:0] eps_q;
  logic [47:0] pcut_q, dcut_q, ptr_q, dtr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SIGMA_RST;
      eps_q   <= EPS_RST;
      cut_q   <= CUTOFF_RST;
      pcut_q  <= '0;
      dcut_q  <= '0;
      trd_q   <= TRUNC_RST;
      ptr_q   <= '0;
      dtr_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (sle_cfg_e'(cfg_idx_i))
        REG_SIGMA:      sigma_q <= cfg_data_i[31:0];
        REG_WELL_DEPTH: eps_q   <= cfg_data_i[46:0];
        REG_CUTOFF:     cut_q   <= cfg_data_i[31:0];
        REG_POT_CUTOFF: pcut_q  <= cfg_data_i;
        REG_DER_CUTOFF: dcut_q  <= cfg_data_i;
        REG_TRUNC:      trd_q   <= cfg_data_i[31:0];
        REG_POT_TRUNC:  ptr_q   <= cfg_data_i;
        REG_DER_TRUNC:  dtr_q   <= cfg_data_i;
      endcase
    end
  end

  // ---------------- global advance: the pipeline moves unless the output stalls
  logic out_vld_q;
  logic adv;
  assign adv         = !out_vld_q || rsp_o.ready;
  assign req_i.ready = adv;

  // ---------------- divider 1: r = sigma * 2^32 / x
  logic        d1_vld;
  logic [63:0] d1_quo;
  logic [32:0] d1_side;

  sle_div_pipe #(
    .NUM_W (64),
    .DEN_W (31),
    .STEP  (DIV_STEP),
    .SIDE_W(33)
  ) u_div_r (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (req_i.valid),
    .num_i ({sigma_q, 32'b0}),
    .den_i (req_i.distance[30:0]),
    .side_i({req_i.mode, req_i.distance}),
    .vld_o (d1_vld),
    .quo_o (d1_quo),
    .side_o(d1_side)
  );

  // ---------------- classify the request and start the power chain
  logic [63:0] r_sat;
  sle_ctx_t    ctx_a;
  always_comb begin
    r_sat    = d1_quo[63] ? CAPV : d1_quo;
    ctx_a.x  = d1_side[31:0];
    priority if (d1_side[31]) begin
      ctx_a.cs = CS_NEG;
    end else if (d1_side[32] && (d1_side[31:0] < trd_q)) begin
      ctx_a.cs = CS_TRUNC;
    end else if (d1_side[31:0] >= cut_q) begin
      ctx_a.cs = CS_CUT;
    end else if (d1_side[31:0] == 32'd0) begin
      ctx_a.cs = CS_ZERO;
    end else begin
      ctx_a.cs = CS_LJ;
    end
  end

  logic [N_MID-1:0] pv_q;  // valid bits of stages A..M

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (adv) begin
      pv_q <= {pv_q[N_MID-2:0], d1_vld};
    end
  end

  // stage payloads
  sle_pp_t            a_pp_q, c_pp_q, e_pp_q, g_pp_q;
  sle_pp_t            j_pp1_q, j_ppk_q, j_ppc_q, j_ppt_q;
  logic [63:0]        a_r_q, b_r_q, b_r2_q, d_r3_q, f_q_q, g_q_q, h_q_q, h_es_q, i_es_q;
  logic [63:0]        i_m1_q, i_mk_q, i_mc_q, i_mt_q;
  logic               i_n1_q, i_nk_q, i_nc_q, i_nt_q;
  logic               j_n1_q, j_nk_q, j_nc_q, j_nt_q;
  logic [63:0]        k_p1_q, k_pk_q, l_m24_q, m_m24_q;
  logic signed [63:0] k_c_q, k_t_q, l_c_q, l_pot_q, l_ptr_q, m_pot_q, m_ptr_q;
  logic               k_n1_q, k_nk_q, l_nk_q, m_nk_q;
  sle_ctx_t           a_ctx_q, b_ctx_q, c_ctx_q, d_ctx_q, e_ctx_q, f_ctx_q, g_ctx_q;
  sle_ctx_t           h_ctx_q, i_ctx_q, j_ctx_q, k_ctx_q, l_ctx_q, m_ctx_q;

  // stage I operands: q - 1, 1 - 2q and the distance offsets
  logic signed [63:0] b1, k_fac, dxc, dxt;
  logic [63:0]        two_q, s2q;
  always_comb begin
    b1    = $signed(h_q_q) - ONEQ;
    two_q = {h_q_q[62:0], 1'b0};
    s2q   = (two_q > CAPV) ? CAPV : two_q;
    k_fac = ONEQ - $signed(s2q);
    dxc   = $signed((64'(h_ctx_q.x) - 64'(cut_q)) << 8);
    dxt   = $signed((64'(h_ctx_q.x) - 64'(trd_q)) << 8);
  end

  // stage L: scale by 4 and 24, subtract the cutoff potential
  logic signed [63:0] lj;
  logic [63:0]        m4, m24;
  always_comb begin
    m4  = (k_p1_q > CAP_DIV4) ? CAPV : (k_p1_q << 2);
    m24 = (k_pk_q > CAP_DIV24) ? CAPV : ((k_pk_q << 4) + (k_pk_q << 3));
    lj  = mk(k_n1_q, m4);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // A: r*r partials
      a_pp_q  <= pp_of(r_sat, r_sat);
      a_r_q   <= r_sat;
      a_ctx_q <= ctx_a;
      // B: r^2
      b_r2_q  <= umulq_fin(a_pp_q);
      b_r_q   <= a_r_q;
      b_ctx_q <= a_ctx_q;
      // C, D: r^3
      c_pp_q  <= pp_of(b_r2_q, b_r_q);
      c_ctx_q <= b_ctx_q;
      d_r3_q  <= umulq_fin(c_pp_q);
      d_ctx_q <= c_ctx_q;
      // E, F: q = r^6
      e_pp_q  <= pp_of(d_r3_q, d_r3_q);
      e_ctx_q <= d_ctx_q;
      f_q_q   <= umulq_fin(e_pp_q);
      f_ctx_q <= e_ctx_q;
      // G, H: es = eps * q
      g_pp_q  <= pp_of({17'b0, eps_q}, f_q_q);
      g_q_q   <= f_q_q;
      g_ctx_q <= f_ctx_q;
      h_es_q  <= umulq_fin(g_pp_q);
      h_q_q   <= g_q_q;
      h_ctx_q <= g_ctx_q;
      // I: sign/magnitude operands
      i_es_q  <= h_es_q;
      i_m1_q  <= mag(b1);
      i_n1_q  <= b1[63];
      i_mk_q  <= mag(k_fac);
      i_nk_q  <= k_fac[63];
      i_mc_q  <= mag(dxc);
      i_nc_q  <= dcut_q[47] != dxc[63];
      i_mt_q  <= mag(dxt);
      i_nt_q  <= dtr_q[47] != dxt[63];
      i_ctx_q <= h_ctx_q;
      // J: four products in parallel
      j_pp1_q <= pp_of(i_es_q, i_m1_q);
      j_ppk_q <= pp_of(i_es_q, i_mk_q);
      j_ppc_q <= pp_of(mag(sx48(dcut_q)), i_mc_q);
      j_ppt_q <= pp_of(mag(sx48(dtr_q)), i_mt_q);
      j_n1_q  <= i_n1_q;
      j_nk_q  <= i_nk_q;
      j_nc_q  <= i_nc_q;
      j_nt_q  <= i_nt_q;
      j_ctx_q <= i_ctx_q;
      // K: finish products
      k_p1_q  <= umulq_fin(j_pp1_q);
      k_pk_q  <= umulq_fin(j_ppk_q);
      k_c_q   <= mk(j_nc_q, umulq_fin(j_ppc_q));
      k_t_q   <= mk(j_nt_q, umulq_fin(j_ppt_q));
      k_n1_q  <= j_n1_q;
      k_nk_q  <= j_nk_q;
      k_ctx_q <= j_ctx_q;
      // L
      l_pot_q <= sat_add(lj, -sx48(pcut_q));
      l_ptr_q <= sat_add(sx48(ptr_q), k_t_q);
      l_c_q   <= k_c_q;
      l_m24_q <= m24;
      l_nk_q  <= k_nk_q;
      l_ctx_q <= k_ctx_q;
      // M: subtract the linear force shift
      m_pot_q <= sat_add(l_pot_q, -l_c_q);
      m_ptr_q <= l_ptr_q;
      m_m24_q <= l_m24_q;
      m_nk_q  <= l_nk_q;
      m_ctx_q <= l_ctx_q;
    end
  end

  // ---------------- divider 2: 24*es*(1-2q) / x, Q.32 out
  d2side_t     d2_in, d2_out;
  logic        d2_vld;
  logic [87:0] d2_quo;

  assign d2_in = '{ctx: m_ctx_q, nk: m_nk_q, pot: m_pot_q, ptr: m_ptr_q};

  sle_div_pipe #(
    .NUM_W (88),
    .DEN_W (31),
    .STEP  (DIV_STEP),
    .SIDE_W($bits(d2side_t))
  ) u_div_d (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (pv_q[N_MID-1]),
    .num_i ({1'b0, m_m24_q[62:0], 24'b0}),
    .den_i (m_ctx_q.x[30:0]),
    .side_i(d2_in),
    .vld_o (d2_vld),
    .quo_o (d2_quo),
    .side_o(d2_out)
  );

  // ---------------- final stage: derivative shift, clamp, select
  logic [63:0]        ljd_mag;
  logic signed [63:0] ljd, der_lj;
  logic [48:0]        cp, cd, ct;
  logic [47:0]        pot_d, der_d;
  sle_status_e        st_d;

  always_comb begin
    ljd_mag = (|d2_quo[87:63]) ? CAPV : {1'b0, d2_quo[62:0]};
    ljd     = mk(d2_out.nk, ljd_mag);
    der_lj  = sat_add(ljd, -sx48(dcut_q));
    cp      = clamp48(d2_out.pot);
    cd      = clamp48(der_lj);
    ct      = clamp48(d2_out.ptr);
    unique case (d2_out.ctx.cs)
      CS_NEG: begin
        pot_d = '0;
        der_d = '0;
        st_d  = ST_NEG;
      end
      CS_TRUNC: begin
        pot_d = ct[47:0];
        der_d = dtr_q;
        st_d  = ct[48] ? ST_SAT : ST_OK;
      end
      CS_ZERO: begin
        pot_d = OMAX48[47:0];
        der_d = OMAX48[47:0];
        st_d  = ST_ZERO;
      end
      CS_LJ: begin
        pot_d = cp[47:0];
        der_d = cd[47:0];
        st_d  = (cp[48] || cd[48]) ? ST_SAT : ST_OK;
      end
      default: begin  // at or beyond cutoff
        pot_d = '0;
        der_d = '0;
        st_d  = ST_OK;
      end
    endcase
  end

  logic [47:0] out_pot_q, out_der_q;
  sle_status_e out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pot_q <= pot_d;
      out_der_q <= der_d;
      out_st_q  <= st_d;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.potential  = $signed(out_pot_q);
  assign rsp_o.derivative = $signed(out_der_q);
  assign rsp_o.status     = out_st_q;

  // ---------------- assertions
  a_stall_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while output stalled");

  a_zero_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_ZERO |->
      rsp_o.potential == OMAX48[47:0] && rsp_o.derivative == OMAX48[47:0])
    else $error("zero-distance status without saturated outputs");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(d2_vld))
    else $error("result appeared without a request in the last stage");

endmodule
